>>> design/video_register_port_macros.svh
// Assertion macros shared by the register port design.
`ifndef VIDEO_REGISTER_PORT_MACROS_SVH
`define VIDEO_REGISTER_PORT_MACROS_SVH

// Condition must never hold outside reset.
`define VRP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define VRP_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define VRP_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/vrp_pkg.sv
// Shared types, codes and helper functions of the register port.
package vrp_pkg;

    localparam int unsigned NAME_BYTES_DEF = 2048;
    localparam int unsigned SPRITE_BYTES   = 256;
    localparam int unsigned SPRITE_AW      = 8;
    localparam int unsigned PAL_BYTES      = 32;
    localparam int unsigned PAL_AW         = 5;

    localparam logic [13:0] PAL_BASE = 14'h3F00;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_VBL_SET  = 2'd2,
        OP_VBL_CLR  = 2'd3
    } t_op;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPADDR = 3'd3;
    localparam logic [2:0] REG_SPDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [2:0] MIR_HORIZ  = 3'd0;
    localparam logic [2:0] MIR_VERT   = 3'd1;
    localparam logic [2:0] MIR_LOW    = 3'd2;
    localparam logic [2:0] MIR_HIGH   = 3'd3;
    localparam logic [2:0] MIR_FOUR   = 3'd4;

    // How the second stage forms the read byte and the buffer.
    typedef enum logic [2:0] {
        K_FIXED,
        K_BUF_PAT,
        K_BUF_NAME,
        K_PAL,
        K_SPR
    } t_kind;

    // Physical table for a logical table quadrant.
    function automatic logic [1:0] table_sel(input logic [2:0] mode, input logic [1:0] quad);
        logic [1:0] sel;
        begin
            unique case (mode)
                MIR_VERT: sel = {1'b0, quad[0]};
                MIR_LOW:  sel = 2'd0;
                MIR_HIGH: sel = 2'd1;
                MIR_FOUR: sel = quad;
                default:  sel = {1'b0, quad[1]};
            endcase
            return sel;
        end
    endfunction

    // Raw name-table offset before the wrap to the memory size.
    function automatic logic [11:0] name_raw(input logic [2:0] mode, input logic [11:0] a);
        return {table_sel(mode, a[11:10]), a[9:0]};
    endfunction

    // Palette entry with the backdrop aliases folded down.
    function automatic logic [4:0] pal_index(input logic [4:0] a);
        logic [4:0] idx;
        begin
            idx = a;
            if (a[4] && (a[1:0] == 2'd0)) begin
                idx[4] = 1'b0;
            end
            return idx;
        end
    endfunction

endpackage

>>> design/vrp_flag_ram.sv
// Small synchronous RAM whose entries read as zero until written.
module vrp_flag_ram #(
    parameter int unsigned DEPTH = vrp_pkg::PAL_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [7:0]               i_wdata,
    output logic [7:0]               o_rdata
);
    import vrp_pkg::*;

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rdata;

    // Clear the written marks at reset, set them on each write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    // Write and registered read; unwritten entries read as zero.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_addr] ? r_mem[i_addr] : 8'd0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/vrp_name_ram.sv
// Name-table RAM with size wrap and a zeroing sweep after reset.
module vrp_name_ram #(
    parameter int unsigned NAME_BYTES = vrp_pkg::NAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic        i_re,
    input  logic [11:0] i_raw_index,
    input  logic [7:0]  i_wdata,
    output logic [7:0]  o_rdata,
    output logic        o_busy
);
    import vrp_pkg::*;

    localparam int unsigned AW   = $clog2(NAME_BYTES);
    localparam logic [12:0] SIZE = 13'(NAME_BYTES);
    localparam logic [AW-1:0] LAST = AW'(NAME_BYTES - 1);

    logic [7:0]    r_mem [NAME_BYTES];
    logic [7:0]    r_rdata;
    logic          r_busy;
    logic [AW-1:0] r_clr_idx;
    logic [12:0]   w_wide;
    logic [12:0]   w_wrapped;
    logic [AW-1:0] w_index;

    // Wrap the offset once; it stays below twice the size.
    always_comb begin
        w_wide    = {1'b0, i_raw_index};
        w_wrapped = (w_wide >= SIZE) ? (w_wide - SIZE) : w_wide;
        w_index   = w_wrapped[AW-1:0];
    end

    // Sweep every entry to zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Single port: sweep write, item write or registered read.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= 8'd0;
        end else if (i_we) begin
            r_mem[w_index] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[w_index];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

>>> design/video_register_port.sv
// Top level of the CPU register port of the tile video unit.
// Input channel (i_valid/o_ready): one CPU register access or vblank event
// per transfer, with the pattern byte and sprite flags sampled alongside.
// Output channel (o_valid/i_ready): exactly one result per input transfer,
// in order: read byte, pattern write flag and pattern address.
// Configuration channel (i_cfg_valid/o_cfg_ready): mirroring mode, always
// ready; write it only while no transfer is in flight.
// Each result passes the second-stage register, then the output register
// that drives o_valid; a stall can hold it in either.
// Throughput: one transfer per cycle while no stall or sweep holds o_ready;
// register state is updated at the input transfer and each memory is read
// there into a register for the second stage, no conflict between neighbours.
// Reset: the register state and valid flags clear; the name-table RAM is
// swept to zero entry by entry, during which o_ready stays low. Sprite and
// palette RAM read as zero until written.
// Stall: when i_ready is low the output holds, the second stage holds one
// more item, and o_ready falls until the output moves on.
`include "video_register_port_macros.svh"
module video_register_port #(
    parameter int unsigned NAME_BYTES = vrp_pkg::NAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_pattern_data,
    input  logic        i_sprite_overflow,
    input  logic        i_sprite_zero_hit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_pattern_write,
    output logic [12:0] o_pattern_addr,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_mirror_mode
);
    import vrp_pkg::*;

    // Architectural registers
    logic [2:0]  r_mirror;
    logic [15:0] r_temp_addr;
    logic [15:0] r_vram_addr;
    logic [2:0]  r_fine_x;
    logic        r_toggle;
    logic [7:0]  r_buffer;
    logic [7:0]  r_last;
    logic        r_step_32;
    logic        r_vblank;
    logic [7:0]  r_sprite_addr;

    // Second stage
    logic        r_s1_valid;
    t_kind       r_s1_kind;
    logic [7:0]  r_s1_rd;
    logic [7:0]  r_s1_pat;
    logic        r_s1_pw;
    logic [12:0] r_s1_pa;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_out_rd;
    logic        r_out_pw;
    logic [12:0] r_out_pa;

    logic        w_busy;
    logic        w_accept;
    logic        w_s1_adv;
    logic [13:0] w_a14;
    logic        w_is_pat;
    logic        w_is_pal;
    logic        w_is_read;
    logic        w_is_write;
    logic        w_data_acc;
    logic [15:0] w_step;
    logic        w_name_we;
    logic        w_name_re;
    logic        w_pal_we;
    logic        w_pal_re;
    logic        w_spr_we;
    logic        w_spr_re;
    logic [7:0]  w_name_rdata;
    logic [7:0]  w_pal_rdata;
    logic [7:0]  w_spr_rdata;
    t_kind       n_s1_kind;
    logic [7:0]  n_s1_rd;
    logic        n_s1_pw;
    logic [12:0] n_s1_pa;
    logic [7:0]  n_out_rd;
    logic [7:0]  n_buffer;

    // Handshakes
    assign w_s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !w_busy && (!r_s1_valid || w_s1_adv);
    assign w_accept  = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // Decode the transfer against the current data address
    always_comb begin
        w_a14      = r_vram_addr[13:0];
        w_is_pat   = !w_a14[13];
        w_is_pal   = (w_a14 >= PAL_BASE);
        w_is_read  = (t_op'(i_operation) == OP_READ);
        w_is_write = (t_op'(i_operation) == OP_WRITE);
        w_data_acc = w_accept && (w_is_read || w_is_write) && (i_reg_index == REG_DATA);
        w_step     = r_step_32 ? 16'd32 : 16'd1;
        w_name_we  = w_data_acc && w_is_write && !w_is_pat && !w_is_pal;
        w_name_re  = w_data_acc && w_is_read && !w_is_pat;
        w_pal_we   = w_data_acc && w_is_write && w_is_pal;
        w_pal_re   = w_data_acc && w_is_read && w_is_pal;
        w_spr_we   = w_accept && w_is_write && (i_reg_index == REG_SPDATA);
        w_spr_re   = w_accept && w_is_read && (i_reg_index == REG_SPDATA);
    end

    vrp_name_ram #(
        .NAME_BYTES (NAME_BYTES)
    ) u_name (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (w_name_we),
        .i_re        (w_name_re),
        .i_raw_index (name_raw(r_mirror, w_a14[11:0])),
        .i_wdata     (i_write_data),
        .o_rdata     (w_name_rdata),
        .o_busy      (w_busy)
    );

    vrp_flag_ram #(
        .DEPTH (PAL_BYTES)
    ) u_pal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_pal_we),
        .i_re    (w_pal_re),
        .i_addr  (pal_index(w_a14[PAL_AW-1:0])),
        .i_wdata (i_write_data),
        .o_rdata (w_pal_rdata)
    );

    vrp_flag_ram #(
        .DEPTH (SPRITE_BYTES)
    ) u_spr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_spr_we),
        .i_re    (w_spr_re),
        .i_addr  (r_sprite_addr[SPRITE_AW-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (w_spr_rdata)
    );

    // First stage: classify the result of the transfer
    always_comb begin
        n_s1_kind = K_FIXED;
        n_s1_rd   = 8'd0;
        n_s1_pw   = 1'b0;
        n_s1_pa   = 13'd0;
        if (w_is_read) begin
            unique case (i_reg_index)
                REG_STATUS: begin
                    n_s1_rd = {r_vblank, i_sprite_zero_hit, i_sprite_overflow, r_last[4:0]};
                end
                REG_SPDATA: begin
                    n_s1_kind = K_SPR;
                end
                REG_DATA: begin
                    if (w_is_pat) begin
                        n_s1_kind = K_BUF_PAT;
                        n_s1_pa   = w_a14[12:0];
                    end else if (w_is_pal) begin
                        n_s1_kind = K_PAL;
                    end else begin
                        n_s1_kind = K_BUF_NAME;
                    end
                end
                default: begin
                    n_s1_kind = K_FIXED;
                end
            endcase
        end else if (w_is_write && (i_reg_index == REG_DATA) && w_is_pat) begin
            n_s1_pw = 1'b1;
            n_s1_pa = w_a14[12:0];
        end
    end

    // Second stage: form the read byte and the next read buffer
    always_comb begin
        n_out_rd = r_s1_rd;
        n_buffer = r_buffer;
        unique case (r_s1_kind)
            K_BUF_PAT: begin
                n_out_rd = r_buffer;
                n_buffer = r_s1_pat;
            end
            K_BUF_NAME: begin
                n_out_rd = r_buffer;
                n_buffer = w_name_rdata;
            end
            K_PAL: begin
                n_out_rd = w_pal_rdata;
                n_buffer = w_name_rdata;
            end
            K_SPR: begin
                n_out_rd = w_spr_rdata;
            end
            default: begin
                n_out_rd = r_s1_rd;
            end
        endcase
    end

    // Update register state at each input transfer, and the mirroring at each configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror      <= MIR_HORIZ;
            r_temp_addr   <= '0;
            r_vram_addr   <= '0;
            r_fine_x      <= '0;
            r_toggle      <= 1'b0;
            r_last        <= '0;
            r_step_32     <= 1'b0;
            r_vblank      <= 1'b0;
            r_sprite_addr <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mirror <= i_mirror_mode;
            end
            if (w_accept) begin
                unique case (t_op'(i_operation))
                    OP_VBL_SET: r_vblank <= 1'b1;
                    OP_VBL_CLR: r_vblank <= 1'b0;
                    OP_READ: begin
                        if (i_reg_index == REG_STATUS) begin
                            r_vblank <= 1'b0;
                            r_toggle <= 1'b0;
                        end
                        if (i_reg_index == REG_DATA) begin
                            r_vram_addr <= r_vram_addr + w_step;
                        end
                    end
                    OP_WRITE: begin
                        r_last <= i_write_data;
                        unique case (i_reg_index)
                            REG_CTRL: begin
                                r_step_32          <= i_write_data[2];
                                r_temp_addr[11:10] <= i_write_data[1:0];
                            end
                            REG_SPADDR: r_sprite_addr <= i_write_data;
                            REG_SPDATA: r_sprite_addr <= r_sprite_addr + 8'd1;
                            REG_SCROLL: begin
                                if (!r_toggle) begin
                                    r_temp_addr[4:0] <= i_write_data[7:3];
                                    r_fine_x         <= i_write_data[2:0];
                                    r_toggle         <= 1'b1;
                                end else begin
                                    r_temp_addr[14:12] <= i_write_data[2:0];
                                    r_temp_addr[9:5]   <= i_write_data[7:3];
                                    r_toggle           <= 1'b0;
                                end
                            end
                            REG_ADDR: begin
                                if (!r_toggle) begin
                                    r_temp_addr[14:8] <= {1'b0, i_write_data[5:0]};
                                    r_toggle          <= 1'b1;
                                end else begin
                                    r_temp_addr[7:0] <= i_write_data;
                                    r_vram_addr      <= {r_temp_addr[15:8], i_write_data};
                                    r_toggle         <= 1'b0;
                                end
                            end
                            REG_DATA: r_vram_addr <= r_vram_addr + w_step;
                            default: begin
                            end
                        endcase
                    end
                    default: begin
                        r_vblank <= r_vblank;
                    end
                endcase
            end
        end
    end

    // Advance the stage and output valid flags, and the read buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_buffer    <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_buffer    <= n_buffer;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold stage and output payloads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind <= n_s1_kind;
            r_s1_rd   <= n_s1_rd;
            r_s1_pat  <= i_pattern_data;
            r_s1_pw   <= n_s1_pw;
            r_s1_pa   <= n_s1_pa;
        end
        if (w_s1_adv) begin
            r_out_rd <= n_out_rd;
            r_out_pw <= r_s1_pw;
            r_out_pa <= r_s1_pa;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_out_rd;
    assign o_pattern_write = r_out_pw;
    assign o_pattern_addr  = r_out_pa;

    // Checks
    `VRP_NEVER(a_no_accept_clear, i_clk, i_rst_n, w_busy && r_s1_valid, "item during clear")
    `VRP_IMPLIES(a_stall_cause, i_clk, i_rst_n, r_s1_valid && !w_s1_adv, r_out_valid && !i_ready, "stage held without output stall")
    `VRP_NEXT(a_status_clear, i_clk, i_rst_n, w_accept && w_is_read && (i_reg_index == REG_STATUS), !r_toggle && !r_vblank, "status read did not clear flags")
    `VRP_NEXT(a_data_step, i_clk, i_rst_n, w_data_acc, r_vram_addr == ($past(r_vram_addr) + $past(w_step)), "data address did not advance")

    // Fine scroll is held for the renderer and kept visible here.
    logic w_unused;
    assign w_unused = ^{r_fine_x, r_temp_addr[15]};

endmodule

>>> bench/register_port_checker.sv
// Checker for the video register port: predicts each result and compares it.
module register_port_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_pattern_data,
    input  logic        i_sprite_overflow,
    input  logic        i_sprite_zero_hit,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [7:0]  i_read_data,
    input  logic        i_pattern_write,
    input  logic [12:0] i_pattern_addr,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_mirror_mode,
    output int          o_errors,
    output int          o_pending
);
    import vrp_pkg::*;

    typedef struct packed {
        logic [7:0]  rd;
        logic        pw;
        logic [12:0] pa;
    } t_access_result;

    // Shadow copy of the port state
    logic [2:0]  mirror;
    logic [15:0] t_addr;
    logic [15:0] v_addr;
    logic [2:0]  fx;
    logic        toggle;
    logic [7:0]  rd_buf;
    logic [7:0]  last_wr;
    logic        inc32;
    logic        vbl;
    logic [7:0]  spr_ptr;
    logic [7:0]  spr_ram [256];
    logic [7:0]  name_ram [2048];
    logic [7:0]  pal_ram [32];

    t_access_result results_due[$];

    // Map a name-table address to its physical byte for the given mirroring
    function automatic logic [10:0] name_slot(input logic [2:0] mode, input logic [13:0] addr);
        logic [1:0]  quad;
        logic [1:0]  tbl;
        logic [11:0] off;
        quad = addr[11:10];
        case (mode)
            MIR_VERT: tbl = {1'b0, quad[0]};
            MIR_LOW:  tbl = 2'd0;
            MIR_HIGH: tbl = 2'd1;
            MIR_FOUR: tbl = quad;
            default:  tbl = {1'b0, quad[1]};
        endcase
        off = {tbl, addr[9:0]};
        return off[10:0];
    endfunction

    // Fold the backdrop aliases of the palette
    function automatic logic [4:0] pal_slot(input logic [13:0] addr);
        logic [4:0] p;
        p = addr[4:0];
        if (p[4] && p[1:0] == 2'd0) begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

    task automatic clear_shadow();
        mirror = MIR_HORIZ;
        t_addr = '0; v_addr = '0; fx = '0; toggle = 1'b0;
        rd_buf = '0; last_wr = '0; inc32 = 1'b0; vbl = 1'b0; spr_ptr = '0;
        for (int i = 0; i < 256; i++) spr_ram[i] = '0;
        for (int i = 0; i < 2048; i++) name_ram[i] = '0;
        for (int i = 0; i < 32; i++) pal_ram[i] = '0;
        results_due.delete();
    endtask

    // Work out the result of one transfer and advance the shadow state
    task automatic predict_access(output t_access_result r);
        logic [13:0] a;
        logic [7:0]  v;
        logic [7:0]  wd;
        r = '0;
        wd = i_write_data;
        a = v_addr[13:0];
        case (t_op'(i_operation))
            OP_VBL_SET: vbl = 1'b1;
            OP_VBL_CLR: vbl = 1'b0;
            OP_READ: begin
                if (i_reg_index == REG_STATUS) begin
                    r.rd = {vbl, i_sprite_zero_hit, i_sprite_overflow, last_wr[4:0]};
                    vbl = 1'b0;
                    toggle = 1'b0;
                end else if (i_reg_index == REG_SPDATA) begin
                    r.rd = spr_ram[spr_ptr];
                end else if (i_reg_index == REG_DATA) begin
                    if (a < 14'h2000) begin
                        v = i_pattern_data;
                        r.pa = a[12:0];
                    end else if (a < 14'h3F00) begin
                        v = name_ram[name_slot(mirror, a)];
                    end else begin
                        v = pal_ram[pal_slot(a)];
                    end
                    if (a < 14'h3F00) begin
                        r.rd = rd_buf;
                        rd_buf = v;
                    end else begin
                        r.rd = v;
                        rd_buf = name_ram[name_slot(mirror, a - 14'h1000)];
                    end
                    v_addr = v_addr + (inc32 ? 16'd32 : 16'd1);
                end
            end
            default: begin
                last_wr = wd;
                case (i_reg_index)
                    REG_CTRL: begin
                        inc32 = wd[2];
                        t_addr[11:10] = wd[1:0];
                    end
                    REG_SPADDR: spr_ptr = wd;
                    REG_SPDATA: begin
                        spr_ram[spr_ptr] = wd;
                        spr_ptr = spr_ptr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!toggle) begin
                            t_addr[4:0] = wd[7:3];
                            fx = wd[2:0];
                        end else begin
                            t_addr[14:12] = wd[2:0];
                            t_addr[9:5] = wd[7:3];
                        end
                        toggle = !toggle;
                    end
                    REG_ADDR: begin
                        if (!toggle) begin
                            t_addr[14:8] = {1'b0, wd[5:0]};
                        end else begin
                            t_addr[7:0] = wd;
                            v_addr = t_addr;
                        end
                        toggle = !toggle;
                    end
                    REG_DATA: begin
                        if (a < 14'h2000) begin
                            r.pw = 1'b1;
                            r.pa = a[12:0];
                        end else if (a < 14'h3F00) begin
                            name_ram[name_slot(mirror, a)] = wd;
                        end else begin
                            pal_ram[pal_slot(a)] = wd;
                        end
                        v_addr = v_addr + (inc32 ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
        endcase
    endtask

    // Watch the three channels at each edge
    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result want;
        if (!i_rst_n) begin
            clear_shadow();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                mirror = i_mirror_mode;
            end
            if (i_out_valid && i_ready) begin
                got = '{i_read_data, i_pattern_write, i_pattern_addr};
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing expected: read_data %0h", got.rd);
                    o_errors++;
                end else begin
                    want = results_due.pop_front();
                    if (got.rd !== want.rd) begin
                        $error("read_data expected %0h actual %0h", want.rd, got.rd);
                        o_errors++;
                    end
                    if (got.pw !== want.pw) begin
                        $error("pattern_write expected %0h actual %0h", want.pw, got.pw);
                        o_errors++;
                    end
                    if (got.pa !== want.pa) begin
                        $error("pattern_addr expected %0h actual %0h", want.pa, got.pa);
                        o_errors++;
                    end
                end
            end
            if (i_valid && i_in_ready) begin
                predict_access(want);
                results_due.push_back(want);
            end
        end
        o_pending = results_due.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the register port bench: clock, reset, stimulus and verdict.
module testbench;
    import vrp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [2:0]  i_reg_index;
    logic [7:0]  i_write_data;
    logic [7:0]  i_pattern_data;
    logic        i_sprite_overflow;
    logic        i_sprite_zero_hit;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_read_data;
    logic        o_pattern_write;
    logic [12:0] o_pattern_addr;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_mirror_mode;

    int   errors;
    int   pending;
    int   sent;
    int   stall_left;
    logic quiet;

    video_register_port DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_reg_index(i_reg_index),
        .i_write_data(i_write_data), .i_pattern_data(i_pattern_data),
        .i_sprite_overflow(i_sprite_overflow), .i_sprite_zero_hit(i_sprite_zero_hit),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_read_data(o_read_data), .o_pattern_write(o_pattern_write),
        .o_pattern_addr(o_pattern_addr),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_mirror_mode(i_mirror_mode)
    );

    register_port_checker CHK (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_ready(o_ready),
        .i_operation(i_operation), .i_reg_index(i_reg_index),
        .i_write_data(i_write_data), .i_pattern_data(i_pattern_data),
        .i_sprite_overflow(i_sprite_overflow), .i_sprite_zero_hit(i_sprite_zero_hit),
        .i_out_valid(o_valid), .i_ready(i_ready),
        .i_read_data(o_read_data), .i_pattern_write(o_pattern_write),
        .i_pattern_addr(o_pattern_addr),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_mirror_mode(i_mirror_mode),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // Receiver stalls in short bursts, none once the run goes quiet
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Offer one access and hold it until the transfer
    task automatic put_access(input t_op op, input logic [2:0] rg, input logic [7:0] wd);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_reg_index <= rg;
        i_write_data <= wd;
        i_pattern_data <= 8'($urandom_range(0, 255));
        i_sprite_overflow <= 1'($urandom_range(0, 1));
        i_sprite_zero_hit <= 1'($urandom_range(0, 1));
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic reg_write(input logic [2:0] rg, input logic [7:0] wd);
        put_access(OP_WRITE, rg, wd);
    endtask

    task automatic reg_read(input logic [2:0] rg);
        put_access(OP_READ, rg, 8'($urandom_range(0, 255)));
    endtask

    // Drain outstanding results, then change the mirroring
    task automatic set_mirroring(input logic [2:0] mode);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_mirror_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // One random sequence, mostly well formed
    task automatic random_sequence();
        logic [7:0] hi;
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                case ($urandom_range(0, 3))
                    0: hi = 8'($urandom_range(8'h00, 8'h1F));
                    1: hi = 8'($urandom_range(8'h20, 8'h3E));
                    2: hi = 8'h3F;
                    default: hi = 8'($urandom_range(0, 255));
                endcase
                reg_write(REG_ADDR, hi);
                reg_write(REG_ADDR, 8'($urandom_range(0, 255)));
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 1)) reg_read(REG_DATA);
                    else reg_write(REG_DATA, 8'($urandom_range(0, 255)));
                end
            end
            4: reg_write(REG_CTRL, 8'($urandom_range(0, 255)));
            5: begin
                reg_write(REG_SCROLL, 8'($urandom_range(0, 255)));
                reg_write(REG_SCROLL, 8'($urandom_range(0, 255)));
            end
            6: begin
                reg_write(REG_SPADDR, 8'($urandom_range(0, 255)));
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 1)) reg_read(REG_SPDATA);
                    else reg_write(REG_SPDATA, 8'($urandom_range(0, 255)));
                end
            end
            7: begin
                put_access(t_op'(2'($urandom_range(2, 3))), 3'($urandom_range(0, 7)),
                           8'($urandom_range(0, 255)));
                reg_read(REG_STATUS);
            end
            default: put_access(t_op'(2'($urandom_range(0, 3))), 3'($urandom_range(0, 7)),
                                8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        logic [2:0] modes [7];
        modes = '{MIR_FOUR, MIR_VERT, MIR_LOW, MIR_HIGH, 3'd5, 3'd7, MIR_HORIZ};
        sent = 0;
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_operation <= OP_READ;
        i_reg_index <= REG_CTRL;
        i_write_data <= '0;
        i_pattern_data <= '0;
        i_sprite_overflow <= 1'b0;
        i_sprite_zero_hit <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_mirror_mode <= MIR_HORIZ;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: status, write-only reads, latches, palette aliasing, wraps
        put_access(OP_VBL_SET, REG_CTRL, 8'h00);
        reg_write(REG_MASK, 8'hFF);
        reg_read(REG_STATUS);
        reg_read(REG_STATUS);
        reg_read(REG_CTRL);
        reg_read(REG_MASK);
        reg_read(REG_SPADDR);
        reg_read(REG_SCROLL);
        reg_read(REG_ADDR);
        reg_write(REG_SCROLL, 8'hFF);
        reg_write(REG_SCROLL, 8'h00);
        reg_write(REG_ADDR, 8'h3F);
        reg_write(REG_ADDR, 8'h10);
        reg_write(REG_DATA, 8'hFF);
        reg_write(REG_ADDR, 8'h3F);
        reg_write(REG_ADDR, 8'h00);
        reg_read(REG_DATA);
        reg_write(REG_SPADDR, 8'hFF);
        reg_write(REG_SPDATA, 8'hAA);
        reg_read(REG_SPDATA);
        reg_write(REG_CTRL, 8'hFF);
        reg_write(REG_ADDR, 8'hFF);
        reg_write(REG_ADDR, 8'hFF);
        reg_read(REG_DATA);
        reg_write(REG_DATA, 8'h55);
        reg_write(REG_CTRL, 8'h00);
        put_access(OP_VBL_CLR, REG_DATA, 8'h00);

        // Random phases, one per mirroring setting, the last without idling
        foreach (modes[p]) begin
            set_mirroring(modes[p]);
            if (p == 6) quiet = 1'b1;
            while (sent < 27 + (p + 1) * 132) random_sequence();
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d accesses over seven mirroring settings, including modes above four,",
                 sent);
        $display("with pattern, name-table and palette data traffic under random stalls.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
